// ===== hw/rtl/tlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminated line receiver package
// Shared sizes, request codes, register indexes and types of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

  // Line store holds the longest line plus room for two terminator bytes.
  localparam int BUF_LEN   = 64;
  localparam int DEPTH     = BUF_LEN + 2;
  localparam int AW        = $clog2(DEPTH);
  localparam int POS_W     = $clog2(DEPTH + 1);
  localparam int BYTE_W    = 8;
  localparam int MAXLEN_W  = 7;
  localparam int CFG_W     = 8;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_TERM_FIRST  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TERM_SECOND = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_TERM = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN     = 2'd3;

  localparam logic [BYTE_W-1:0]   RST_TERM_FIRST  = 8'd13;
  localparam logic [BYTE_W-1:0]   RST_TERM_SECOND = 8'd10;
  localparam logic                RST_DOUBLE_TERM = 1'b1;
  localparam logic [MAXLEN_W-1:0] RST_MAX_LEN     = 7'd64;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_TAKE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ZERO,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   term_first;
    logic [BYTE_W-1:0]   term_second;
    logic                double_term;
    logic [MAXLEN_W-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlr_in_if.sv =====
// ----------------------------------------------------------------------------
// Receiver request channel
// Valid/ready channel carrying one request to the line receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_in_if;
  import tlr_pkg::*;

  logic                     valid;
  logic                     ready;
  tlr_pkg::req_t            req_type;
  logic [BYTE_W-1:0]        rx_byte;
  logic [POS_W-1:0]         read_index;

  modport source (output valid, output req_type, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input read_index,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlr_out_if.sv =====
// ----------------------------------------------------------------------------
// Receiver result channel
// Valid/ready channel carrying one result per request from the line receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_out_if;
  import tlr_pkg::*;

  logic              valid;
  logic              ready;
  logic              string_done;
  logic              string_ready;
  logic              overwrite;
  logic [POS_W-1:0]  string_length;
  logic [BYTE_W-1:0] current_byte;
  logic [BYTE_W-1:0] read_char;
  logic [POS_W-1:0]  fill_index;

  modport source (output valid, output string_done, output string_ready,
                  output overwrite, output string_length, output current_byte,
                  output read_char, output fill_index, input ready);
  modport sink   (input valid, input string_done, input string_ready,
                  input overwrite, input string_length, input current_byte,
                  input read_char, input fill_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlr_ram.sv =====
// ----------------------------------------------------------------------------
// Line store RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_ram #(
  parameter int DEPTH = 66,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ===== hw/rtl/tlr_line_ctl.sv =====
// ----------------------------------------------------------------------------
// Line receiver controller
// Line state, terminator matching, store sequencing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_line_ctl (
  input  logic                        clk,
  input  logic                        rst,
  input  tlr_pkg::cfg_t               cfg,
  tlr_in_if.sink                      req,
  tlr_out_if.source                   rsp,
  output tlr_pkg::mem_wr_t            mem_wr,
  output logic [tlr_pkg::AW-1:0]      mem_raddr,
  input  logic [tlr_pkg::BYTE_W-1:0]  mem_rdata
);
  import tlr_pkg::*;

  localparam int CW = ((POS_W > MAXLEN_W) ? POS_W : MAXLEN_W) + 1;

  state_t            state, state_next;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     zero_addr;
  logic              rd_oob;

  logic [POS_W-1:0]  wp, wp_next;
  logic              ready_flag, ready_flag_next;
  logic              ovr_flag, ovr_flag_next;
  logic [POS_W-1:0]  line_len, line_len_next;
  logic [BYTE_W-1:0] last_byte, last_byte_next;
  logic              done_next;

  logic              out_valid;
  logic              o_done, o_ready, o_ovr;
  logic [POS_W-1:0]  o_len, o_fill;
  logic [BYTE_W-1:0] o_cur, o_rdchar;

  logic              accept;
  logic [POS_W-1:0]  pos;
  logic [CW-1:0]     ml_ext, limit;
  logic              hit_single, hit_pair, hit_limit, ended, zero_prev;

  assign accept = req.valid && req.ready;
  assign pos    = wp + POS_W'(1);
  assign ml_ext = CW'(cfg.max_len);
  assign limit  = (ml_ext > CW'(BUF_LEN)) ? CW'(BUF_LEN) : ml_ext;

  // With a nonzero write position, the entry just before it always holds the
  // last received byte, so the pair match needs no store read.
  assign hit_single = !cfg.double_term && (req.rx_byte == cfg.term_first);
  assign hit_pair   = cfg.double_term && (wp != '0) && (req.rx_byte == cfg.term_second)
                      && (last_byte == cfg.term_first);
  assign hit_limit  = !hit_single && !hit_pair && (wp != '0)
                      && (CW'(pos) >= limit + CW'(2));
  assign ended      = hit_single || hit_pair || hit_limit;
  assign zero_prev  = hit_pair || hit_limit;

  // Line state after the request at the port.
  always_comb begin
    wp_next         = wp;
    ready_flag_next = ready_flag;
    ovr_flag_next   = ovr_flag;
    line_len_next   = line_len;
    last_byte_next  = last_byte;
    done_next       = 1'b0;
    unique case (req.req_type)
      REQ_BYTE: begin
        last_byte_next  = req.rx_byte;
        ovr_flag_next   = ovr_flag || ready_flag;
        ready_flag_next = ended;
        done_next       = ended;
        wp_next         = ended ? '0 : pos;
        if (ended) begin
          line_len_next = hit_single ? wp : wp - POS_W'(1);
        end
      end
      REQ_TAKE: begin
        ready_flag_next = 1'b0;
      end
      REQ_READ: begin
      end
      REQ_FLUSH: begin
        wp_next         = '0;
        ready_flag_next = 1'b0;
        line_len_next   = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (req.req_type == REQ_FLUSH) begin
            state_next = ST_CLEAR;
          end else if (req.req_type == REQ_READ) begin
            state_next = ST_READ;
          end else if (req.req_type == REQ_BYTE && zero_prev) begin
            state_next = ST_ZERO;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ZERO: state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
    endcase
  end

  // Handshake and store port. Requests are taken only in idle, so a store
  // read never meets a pending write to the same entry.
  always_comb begin
    req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
    mem_raddr = req.read_index[AW-1:0];
    mem_wr    = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = clr_addr;
      end
      ST_IDLE: begin
        if (accept && req.req_type == REQ_BYTE) begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = wp[AW-1:0];
          mem_wr.data = ended ? '0 : req.rx_byte;
        end
      end
      ST_ZERO: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = zero_addr;
      end
      ST_READ: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      wp         <= '0;
      ready_flag <= 1'b0;
      ovr_flag   <= 1'b0;
      line_len   <= '0;
      last_byte  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= (state == ST_CLEAR) ? clr_addr + AW'(1) : '0;
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        wp         <= wp_next;
        ready_flag <= ready_flag_next;
        ovr_flag   <= ovr_flag_next;
        line_len   <= line_len_next;
        last_byte  <= last_byte_next;
        out_valid  <= (req.req_type != REQ_READ);
      end
      if (state == ST_READ) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_done    <= done_next;
      o_ready   <= ready_flag;
      o_ovr     <= ovr_flag_next;
      o_len     <= line_len_next;
      o_cur     <= last_byte_next;
      o_fill    <= wp_next;
      o_rdchar  <= '0;
      zero_addr <= AW'(wp - POS_W'(1));
      rd_oob    <= (req.read_index >= POS_W'(DEPTH));
    end
    if (state == ST_READ) begin
      o_rdchar <= rd_oob ? '0 : mem_rdata;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.string_done   = o_done;
  assign rsp.string_ready  = o_ready;
  assign rsp.overwrite     = o_ovr;
  assign rsp.string_length = o_len;
  assign rsp.current_byte  = o_cur;
  assign rsp.read_char     = o_rdchar;
  assign rsp.fill_index    = o_fill;

  a_flush_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_FLUSH) |=> (state == ST_CLEAR))
    else $error("flush did not start a store sweep");

  a_ready_rewound: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> (wp == '0))
    else $error("line ready with a nonzero write position");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp < POS_W'(DEPTH))
    else $error("write position beyond the line store");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> out_valid)
    else $error("store read produced no result");
endmodule

`default_nettype wire

// ===== hw/rtl/terminated_line_receiver.sv =====
// ----------------------------------------------------------------------------
// Terminated line receiver
// Collects received bytes into a line store and ends lines on a terminator.
// ----------------------------------------------------------------------------
// One result comes back for every request: in the cycle after it is taken, or
// through the read state for a store read. The next request is taken as the
// result leaves. A received byte or a take request returns the block to idle;
// a byte that ends a line on a two-character terminator or on the length limit
// passes through a zeroing state first, because both terminator slots are
// zeroed through the single write port of the line store. A read of a store
// entry passes through the read state because the RAM read port is registered.
// A flush returns its result in the cycle after it is taken and then sweeps the
// store one entry per cycle, during which no request is taken; the same clearing
// pass runs after reset. Configuration writes are taken in any cycle.
`default_nettype none

module terminated_line_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tlr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tlr_pkg::CFG_W-1:0]      cfg_data,
  tlr_in_if.sink                         req,
  tlr_out_if.source                      rsp
);
  import tlr_pkg::*;

  cfg_t              cfg;
  mem_wr_t           mem_wr;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.term_first  <= RST_TERM_FIRST;
      cfg.term_second <= RST_TERM_SECOND;
      cfg.double_term <= RST_DOUBLE_TERM;
      cfg.max_len     <= RST_MAX_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TERM_FIRST:  cfg.term_first  <= cfg_data[BYTE_W-1:0];
        REG_TERM_SECOND: cfg.term_second <= cfg_data[BYTE_W-1:0];
        REG_DOUBLE_TERM: cfg.double_term <= cfg_data[0];
        REG_MAX_LEN:     cfg.max_len     <= cfg_data[MAXLEN_W-1:0];
      endcase
    end
  end

  tlr_line_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tlr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (BYTE_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );
endmodule

`default_nettype wire

// ===== test/terminated_line_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// Terminated line receiver testbench
// Sends byte, take, read and flush requests under several register settings
// and pacing modes, and checks every result against a behavioral line model.
// ----------------------------------------------------------------------------
`default_nettype none

module terminated_line_receiver_tb;
  import tlr_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_LEN    = 300;
  localparam int PHASE_ITEMS = 175;

  typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH, PACE_HOLD} pace_t;

  typedef struct {
    req_t              op;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  idx;
  } line_req_t;

  typedef struct packed {
    logic              done;
    logic              rdy;
    logic              ovw;
    logic [POS_W-1:0]  len;
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] rdc;
    logic [POS_W-1:0]  fill;
  } line_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tlr_in_if  req_ch ();
  tlr_out_if rsp_ch ();

  terminated_line_receiver uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the receiver state and its registers.
  logic [BYTE_W-1:0] shadow_store [DEPTH];
  int unsigned       shadow_pos;
  logic              shadow_ready;
  logic              shadow_ovw;
  int unsigned       shadow_len;
  logic [BYTE_W-1:0] shadow_last;
  cfg_t              shadow_cfg;

  line_req_t req_backlog [$];
  line_rsp_t pending_rsp [$];
  line_req_t drv_item;
  line_rsp_t want;
  pace_t     pace;
  int        queued;
  int        fail_count   = 0;
  int        rsp_count    = 0;
  int        hold_cycles  = 0;
  int        quiet_cycles = 0;

  // Register values the stimulus is shaped around.
  logic [BYTE_W-1:0] cur_tf;
  logic [BYTE_W-1:0] cur_ts;
  logic              cur_dbl;
  int                cur_lim;

  function automatic void wipe_line_store();
    foreach (shadow_store[k]) shadow_store[k] = '0;
  endfunction

  function automatic line_rsp_t line_rx_step(line_req_t r);
    line_rsp_t   o;
    int unsigned pos;
    int unsigned lim;
    bit          ended;
    o = '0;
    o.rdy = shadow_ready;
    case (r.op)
      REQ_BYTE: begin
        if (shadow_pos < DEPTH) shadow_store[shadow_pos] = r.data;
        shadow_last = r.data;
        shadow_pos++;
        pos = shadow_pos;
        if (shadow_ready) shadow_ovw = 1'b1;
        shadow_ready = 1'b0;
        ended = 1'b0;
        lim = (shadow_cfg.max_len > BUF_LEN) ? BUF_LEN : shadow_cfg.max_len;
        if (!shadow_cfg.double_term) begin
          if (r.data == shadow_cfg.term_first) begin
            shadow_store[pos - 1] = '0;
            shadow_len = pos - 1;
            ended = 1'b1;
          end
        end else if (pos > 1 && r.data == shadow_cfg.term_second &&
                     shadow_store[pos - 2] == shadow_cfg.term_first) begin
          shadow_store[pos - 1] = '0;
          shadow_store[pos - 2] = '0;
          shadow_len = pos - 2;
          ended = 1'b1;
        end
        // The length limit applies whenever no terminator ended the line.
        if (!ended && pos > 1 && pos >= lim + 2) begin
          shadow_store[pos - 1] = '0;
          shadow_store[pos - 2] = '0;
          shadow_len = pos - 2;
          ended = 1'b1;
        end
        if (ended) begin
          shadow_ready = 1'b1;
          shadow_pos = 0;
        end
        o.done = ended;
      end
      REQ_TAKE: shadow_ready = 1'b0;
      REQ_READ: o.rdc = (r.idx < DEPTH) ? shadow_store[r.idx] : '0;
      default: begin
        wipe_line_store();
        shadow_pos = 0;
        shadow_ready = 1'b0;
        shadow_len = 0;
      end
    endcase
    o.ovw  = shadow_ovw;
    o.len  = POS_W'(shadow_len);
    o.cur  = shadow_last;
    o.fill = POS_W'(shadow_pos);
    return o;
  endfunction

  function automatic int send_gap_pct(pace_t p);
    return (p == PACE_SEND) ? 77 : (p == PACE_BOTH) ? 28 : 0;
  endfunction

  function automatic int recv_stall_pct(pace_t p);
    return (p == PACE_RECV) ? 77 : (p == PACE_BOTH) ? 28 : 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg <= '{term_first: RST_TERM_FIRST, term_second: RST_TERM_SECOND,
                      double_term: RST_DOUBLE_TERM, max_len: RST_MAX_LEN};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TERM_FIRST:  shadow_cfg.term_first  <= cfg_data;
        REG_TERM_SECOND: shadow_cfg.term_second <= cfg_data;
        REG_DOUBLE_TERM: shadow_cfg.double_term <= cfg_data[0];
        REG_MAX_LEN:     shadow_cfg.max_len     <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request driver: predicts each request as it is taken, then offers the next.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_BYTE;
      req_ch.rx_byte    <= '0;
      req_ch.read_index <= '0;
      wipe_line_store();
      shadow_pos   = 0;
      shadow_ready = 1'b0;
      shadow_ovw   = 1'b0;
      shadow_len   = 0;
      shadow_last  = '0;
    end else begin
      if (req_ch.valid && req_ch.ready) pending_rsp.push_back(line_rx_step(drv_item));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct(pace)) begin
          drv_item = req_backlog.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= drv_item.op;
          req_ch.rx_byte    <= drv_item.data;
          req_ch.read_index <= drv_item.idx;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected %0d, got %0d", rsp_count, name, exp_v, got_v);
    end
  endtask

  // Result monitor and receiver pacing.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result %0d arrived with none pending", rsp_count);
        end else begin
          want = pending_rsp.pop_front();
          check_field("string_done", 8'(want.done), 8'(rsp_ch.string_done));
          check_field("string_ready", 8'(want.rdy), 8'(rsp_ch.string_ready));
          check_field("overwrite", 8'(want.ovw), 8'(rsp_ch.overwrite));
          check_field("string_length", 8'(want.len), 8'(rsp_ch.string_length));
          check_field("current_byte", want.cur, rsp_ch.current_byte);
          check_field("read_char", want.rdc, rsp_ch.read_char);
          check_field("fill_index", 8'(want.fill), 8'(rsp_ch.fill_index));
        end
        rsp_count++;
      end
      // One long hold-off lets the block back up and refuse new requests.
      if (pace == PACE_HOLD && hold_cycles < HOLD_LEN) begin
        hold_cycles++;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct(pace));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(req_t op, logic [BYTE_W-1:0] data, logic [POS_W-1:0] idx);
    line_req_t r;
    r.op   = op;
    r.data = data;
    r.idx  = idx;
    req_backlog.push_back(r);
    queued++;
  endtask

  task automatic push_byte(logic [BYTE_W-1:0] b);
    push_req(REQ_BYTE, b, POS_W'($urandom_range(0, 127)));
  endtask

  task automatic push_read(logic [POS_W-1:0] idx);
    push_req(REQ_READ, BYTE_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic push_op(req_t op);
    push_req(op, BYTE_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 127)));
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == cur_tf || (cur_dbl && b == cur_ts));
    return b;
  endfunction

  // One line of content followed, most of the time, by a proper terminator.
  task automatic push_line();
    int n;
    int k;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) n = $urandom_range(0, (cur_lim < 10) ? cur_lim : 10);
    else if (sel < 90) n = $urandom_range(0, cur_lim + 1);
    else n = cur_lim + 2 + $urandom_range(0, 2);
    for (k = 0; k < n; k++)
      push_byte(($urandom_range(0, 99) < 85) ? plain_byte() : BYTE_W'($urandom_range(0, 255)));
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      push_byte(cur_tf);
      if (cur_dbl) push_byte(cur_ts);
    end else if (sel < 93) begin
      push_byte(cur_ts);
    end else begin
      push_byte(cur_tf);
      push_byte(plain_byte());
    end
  endtask

  task automatic fill_phase(int n);
    int stop;
    int sel;
    int k;
    stop = queued + n;
    while (queued < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) begin
        push_line();
        if ($urandom_range(0, 99) < 60) push_op(REQ_TAKE);
        for (k = $urandom_range(0, 3); k > 0; k--)
          push_read(POS_W'($urandom_range(0, cur_lim + 2)));
      end else if (sel < 96) begin
        for (k = $urandom_range(1, 4); k > 0; k--) begin
          case ($urandom_range(0, 2))
            0: push_byte(BYTE_W'($urandom_range(0, 255)));
            1: push_op(REQ_TAKE);
            default: push_read(POS_W'($urandom_range(0, 127)));
          endcase
        end
      end else begin
        push_op(REQ_FLUSH);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || pending_rsp.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic program_regs(logic [7:0] tf, logic [7:0] ts, logic dbl, logic [7:0] ml);
    write_reg(REG_TERM_FIRST, tf);
    write_reg(REG_TERM_SECOND, ts);
    write_reg(REG_DOUBLE_TERM, CFG_W'(dbl));
    write_reg(REG_MAX_LEN, ml);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_tf  = tf;
    cur_ts  = ts;
    cur_dbl = dbl;
    cur_lim = (ml[MAXLEN_W-1:0] > BUF_LEN) ? BUF_LEN : ml[MAXLEN_W-1:0];
    @(negedge clk);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_TERM_FIRST;
    cfg_data          = '0;
    pace              = PACE_NONE;
    queued            = 0;
    cur_tf            = RST_TERM_FIRST;
    cur_ts            = RST_TERM_SECOND;
    cur_dbl           = RST_DOUBLE_TERM;
    cur_lim           = BUF_LEN;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings: CR LF pair, full length.
    push_op(REQ_TAKE);
    push_read(0);
    push_read(127);
    push_byte(8'h0A);          // second terminator as the first byte of a line
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h0A);          // second terminator without the first before it
    push_byte(8'h0D);
    push_byte(8'h0A);
    push_read(0);
    push_read(4);
    push_read(POS_W'(DEPTH - 1));
    push_op(REQ_TAKE);
    push_op(REQ_TAKE);
    push_byte(8'h0D);
    push_byte(8'h0A);          // empty line, left unread
    push_byte(8'h55);          // overwrites the unread line
    push_read(0);
    push_op(REQ_FLUSH);
    push_read(0);
    push_byte(8'h7F);
    push_op(REQ_FLUSH);
    push_read(POS_W'(DEPTH));
    fill_phase(PHASE_ITEMS);
    drain();

    // Single terminator of zero with a zero length limit.
    program_regs(8'h00, 8'hFF, 1'b0, 8'd0);
    pace = PACE_SEND;
    fill_phase(PHASE_ITEMS);
    drain();

    // Oversized limit saturates; the receiver holds off for a long stretch.
    program_regs(8'hFF, 8'h00, 1'b1, 8'd127);
    pace = PACE_HOLD;
    fill_phase(PHASE_ITEMS);
    drain();

    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 8'd1);
    pace = PACE_RECV;
    fill_phase(PHASE_ITEMS);
    drain();

    // Leave a long partial line behind, then lower the limit under it.
    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 8'd40);
    pace = PACE_BOTH;
    fill_phase(PHASE_ITEMS);
    push_op(REQ_FLUSH);
    repeat (20) push_byte(plain_byte());
    drain();

    program_regs(RST_TERM_FIRST, RST_TERM_SECOND, 1'b1, 8'd5);
    pace = PACE_NONE;
    fill_phase(PHASE_ITEMS);
    drain();

    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
